// File: rtl/abt_pkg.sv
// Package with the types, constants and microcode table of the alpha-beta tracker.
`timescale 1ns / 1ps

package abt_pkg;

    localparam int TRACK_W       = 32;
    localparam int ACC_W         = 64;
    localparam int RES_W         = 34;
    localparam int GAIN_W        = 16;
    localparam int DT_W          = 16;
    localparam int DIV_W         = 60;
    localparam int DIV_CNT_W     = $clog2(DIV_W);
    localparam int PC_W          = 4;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int MUL_A_W       = 48;
    localparam int RECIP_CHUNK_W = 16;
    localparam int RECIP_SHIFT   = 21;

    localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN = 1'd1;

    localparam logic [GAIN_W-1:0] POSITION_GAIN_RESET = 16'd32768;
    localparam logic [GAIN_W-1:0] VELOCITY_GAIN_RESET = 16'd6554;

    // This is ceil(2^53 / 1000), so a multiply and a shift right by 53 divide any
    // magnitude below 2^50 by 1000 exactly. It is applied in three 16-bit chunks,
    // each partial sum shifted right by 16, which leaves a final shift of 21.
    localparam logic [3*RECIP_CHUNK_W-1:0] MS_RECIP = 48'h0831_26E9_78D5;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_RATE,
        OP_RECIP_LO,
        OP_RECIP_MID,
        OP_RECIP_HI,
        OP_PREDICT,
        OP_RESIDUAL,
        OP_MUL_ALPHA,
        OP_POS_UPD,
        OP_MUL_BETA,
        OP_SCALE_MS,
        OP_DIV_DT,
        OP_RATE_UPD,
        OP_INIT_LOAD,
        OP_COMMIT
    } dp_op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_INIT,
        C_DIV_BUSY,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        dp_op_t              op;
        cond_t               cond;
        logic [PC_W-1:0]     target;
    } ucode_t;

    typedef struct packed {
        logic                start;
        logic                negative;
        logic [DIV_W-1:0]    magnitude;
        logic [DT_W-1:0]     divisor;
    } div_req_t;

    localparam logic [PC_W-1:0] STEP_IDLE      = 4'd0;
    localparam logic [PC_W-1:0] STEP_WAIT_DT   = 4'd12;
    localparam logic [PC_W-1:0] STEP_INIT_LOAD = 4'd14;
    localparam logic [PC_W-1:0] STEP_COMMIT    = 4'd15;

    // The commit step is the last entry, so its fall-through wraps to the idle step.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{op: OP_NOP, cond: C_NEVER, target: STEP_IDLE};
        unique case (pc)
            4'd0:    w = '{op: OP_LOAD,      cond: C_NO_INPUT, target: STEP_IDLE};
            4'd1:    w = '{op: OP_MUL_RATE,  cond: C_INIT,     target: STEP_INIT_LOAD};
            4'd2:    w = '{op: OP_RECIP_LO,  cond: C_NEVER,    target: STEP_IDLE};
            4'd3:    w = '{op: OP_RECIP_MID, cond: C_NEVER,    target: STEP_IDLE};
            4'd4:    w = '{op: OP_RECIP_HI,  cond: C_NEVER,    target: STEP_IDLE};
            4'd5:    w = '{op: OP_PREDICT,   cond: C_NEVER,    target: STEP_IDLE};
            4'd6:    w = '{op: OP_RESIDUAL,  cond: C_NEVER,    target: STEP_IDLE};
            4'd7:    w = '{op: OP_MUL_ALPHA, cond: C_NEVER,    target: STEP_IDLE};
            4'd8:    w = '{op: OP_POS_UPD,   cond: C_NEVER,    target: STEP_IDLE};
            4'd9:    w = '{op: OP_MUL_BETA,  cond: C_NEVER,    target: STEP_IDLE};
            4'd10:   w = '{op: OP_SCALE_MS,  cond: C_NEVER,    target: STEP_IDLE};
            4'd11:   w = '{op: OP_DIV_DT,    cond: C_NEVER,    target: STEP_IDLE};
            4'd12:   w = '{op: OP_NOP,       cond: C_DIV_BUSY, target: STEP_WAIT_DT};
            4'd13:   w = '{op: OP_RATE_UPD,  cond: C_ALWAYS,   target: STEP_COMMIT};
            4'd14:   w = '{op: OP_INIT_LOAD, cond: C_NEVER,    target: STEP_IDLE};
            4'd15:   w = '{op: OP_COMMIT,    cond: C_OUT_BUSY, target: STEP_COMMIT};
            default: w = '{op: OP_NOP,       cond: C_ALWAYS,   target: STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic signed [TRACK_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'($signed({1'b0, {(TRACK_W-1){1'b1}}}));
        lo = ACC_W'($signed({1'b1, {(TRACK_W-1){1'b0}}}));
        if (x > hi) begin
            return hi[TRACK_W-1:0];
        end
        if (x < lo) begin
            return lo[TRACK_W-1:0];
        end
        return x[TRACK_W-1:0];
    endfunction

endpackage

// File: rtl/abt_in_if.sv
// Input channel interface carrying one sample transfer.
`timescale 1ns / 1ps

interface abt_in_if import abt_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [DT_W-1:0]               interval_ms;
    logic                          restart;

    modport source (output valid, output sample, output interval_ms, output restart,
                    input ready);
    modport sink   (input valid, input sample, input interval_ms, input restart,
                    output ready);
endinterface

// File: rtl/abt_out_if.sv
// Output channel interface carrying one filtered result transfer.
`timescale 1ns / 1ps

interface abt_out_if import abt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [TRACK_W-1:0] position;
    logic signed [TRACK_W-1:0] rate;
    logic                      initialized_now;

    modport source (output valid, output position, output rate, output initialized_now,
                    input ready);
    modport sink   (input valid, input position, input rate, input initialized_now,
                    output ready);
endinterface

// File: rtl/alpha_beta_tracker_core.sv
// Alpha-beta tracker core: microcoded sequencer over a shared multiplier and divider.
// An item that initializes the track branches straight to the init-load and commit steps.
// An update item waits at the wait step for the serial divide by the interval;
// the divide by 1000 is a three-step reciprocal multiply.
// The next item is accepted in the idle step that follows a commit;
// a result still waiting in the output register holds the commit step.
// Reset clears the track, sets the gains to their defaults and empties the output register.
`timescale 1ns / 1ps

module alpha_beta_tracker_core import abt_pkg::*; #(
    parameter int SAMPLE_BITS    = 16,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    abt_in_if.sink                in_ch,
    abt_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int MEAS_W = SAMPLE_BITS + 4;
    localparam int PROD_W = MUL_A_W + GAIN_W + 1;

    logic [PC_W-1:0]           pc_reg;
    logic [PC_W-1:0]           pc_next;
    ucode_t                    uc;
    logic                      cond_true;

    logic [GAIN_W-1:0]         alpha_reg;
    logic [GAIN_W-1:0]         beta_reg;

    logic signed [TRACK_W-1:0] pos_reg;
    logic signed [TRACK_W-1:0] pos_next;
    logic signed [TRACK_W-1:0] rate_reg;
    logic signed [TRACK_W-1:0] rate_next;
    logic                      track_valid_reg;
    logic                      track_valid_next;

    logic signed [MEAS_W-1:0]  meas_reg;
    logic [DT_W-1:0]           dt_reg;
    logic                      init_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [TRACK_W-1:0] pred_reg;
    logic signed [TRACK_W-1:0] pred_next;
    logic signed [RES_W-1:0]   res_reg;
    logic signed [RES_W-1:0]   res_next;
    logic signed [TRACK_W-1:0] newpos_reg;
    logic signed [TRACK_W-1:0] newpos_next;
    logic signed [TRACK_W-1:0] newrate_reg;
    logic signed [TRACK_W-1:0] newrate_next;
    logic [MUL_A_W-1:0]        scaled_mag_reg;
    logic                      scaled_neg_reg;
    logic signed [ACC_W-1:0]   ms_quot;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [GAIN_W:0]    mul_b;
    logic signed [PROD_W-1:0]  product;
    logic [ACC_W-1:0]          acc_abs;

    div_req_t                  div_req;
    logic                      div_busy;
    logic signed [ACC_W-1:0]   div_q;

    logic                      out_valid_reg;
    logic                      out_busy;
    logic                      commit_go;
    logic                      in_xfer;

    assign uc        = ucode_rom(pc_reg);
    assign out_busy  = out_valid_reg && !out_ch.ready;
    assign commit_go = (uc.op == OP_COMMIT) && !out_busy;
    assign in_xfer   = in_ch.valid && in_ch.ready;

    assign in_ch.ready  = (uc.op == OP_LOAD);
    assign out_ch.valid = out_valid_reg;

    always_comb
    begin
        unique case (uc.cond)
            C_NEVER:    cond_true = 1'b0;
            C_ALWAYS:   cond_true = 1'b1;
            C_NO_INPUT: cond_true = !in_ch.valid;
            C_INIT:     cond_true = init_reg;
            C_DIV_BUSY: cond_true = div_busy;
            C_OUT_BUSY: cond_true = out_busy;
            default:    cond_true = 1'b0;
        endcase
        pc_next = cond_true ? uc.target : pc_reg + 1'b1;
    end

    // One shared multiplier: rate by interval, the rate product by the reciprocal of 1000,
    // or residual by a gain.
    always_comb
    begin
        case (uc.op) inside
            OP_MUL_RATE:               mul_a = MUL_A_W'(rate_reg);
            OP_RECIP_LO:               mul_a = $signed(acc_abs[MUL_A_W-1:0]);
            OP_RECIP_MID, OP_RECIP_HI: mul_a = $signed(scaled_mag_reg);
            default:                   mul_a = MUL_A_W'(res_reg);
        endcase
        case (uc.op)
            OP_MUL_RATE:  mul_b = $signed({1'b0, dt_reg});
            OP_MUL_ALPHA: mul_b = $signed({1'b0, alpha_reg});
            OP_RECIP_LO:  mul_b = $signed({1'b0, MS_RECIP[RECIP_CHUNK_W-1:0]});
            OP_RECIP_MID: mul_b = $signed({1'b0, MS_RECIP[2*RECIP_CHUNK_W-1:RECIP_CHUNK_W]});
            OP_RECIP_HI:  mul_b = $signed({1'b0, MS_RECIP[3*RECIP_CHUNK_W-1:2*RECIP_CHUNK_W]});
            default:      mul_b = $signed({1'b0, beta_reg});
        endcase
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign acc_abs = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign ms_quot = scaled_neg_reg ? -(acc_reg >>> RECIP_SHIFT) : (acc_reg >>> RECIP_SHIFT);

    always_comb
    begin
        div_req.start     = (uc.op == OP_DIV_DT);
        div_req.negative  = acc_reg[ACC_W-1];
        div_req.magnitude = acc_abs[DIV_W-1:0];
        div_req.divisor   = dt_reg;
    end

    abt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_comb
    begin
        acc_next         = acc_reg;
        pred_next        = pred_reg;
        res_next         = res_reg;
        newpos_next      = newpos_reg;
        newrate_next     = newrate_reg;
        pos_next         = pos_reg;
        rate_next        = rate_reg;
        track_valid_next = track_valid_reg;
        unique case (uc.op) inside
            OP_MUL_RATE, OP_MUL_ALPHA, OP_MUL_BETA, OP_RECIP_LO:
                acc_next = ACC_W'(product);
            OP_RECIP_MID, OP_RECIP_HI:
                acc_next = (acc_reg >>> RECIP_CHUNK_W) + ACC_W'(product);
            OP_SCALE_MS:
                acc_next = (acc_reg <<< 10) - (acc_reg <<< 4) - (acc_reg <<< 3);
            OP_PREDICT:
                pred_next = sat32(ACC_W'(pos_reg) + ms_quot);
            OP_RESIDUAL:
                res_next = RES_W'(meas_reg) - RES_W'(pred_reg);
            OP_POS_UPD:
                newpos_next = sat32(ACC_W'(pred_reg) + (acc_reg >>> GAIN_FRAC_BITS));
            OP_RATE_UPD:
                newrate_next = sat32(ACC_W'(rate_reg) + (div_q >>> GAIN_FRAC_BITS));
            OP_INIT_LOAD:
            begin
                newpos_next  = sat32(ACC_W'(meas_reg));
                newrate_next = '0;
            end
            OP_COMMIT:
            begin
                if (!out_busy) begin
                    pos_next         = newpos_reg;
                    rate_next        = newrate_reg;
                    track_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg          <= STEP_IDLE;
            alpha_reg       <= POSITION_GAIN_RESET;
            beta_reg        <= VELOCITY_GAIN_RESET;
            pos_reg         <= '0;
            rate_reg        <= '0;
            track_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            pc_reg          <= pc_next;
            pos_reg         <= pos_next;
            rate_reg        <= rate_next;
            track_valid_reg <= track_valid_next;
            if (cfg_we && (cfg_index == REG_POSITION_GAIN)) begin
                alpha_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_VELOCITY_GAIN)) begin
                beta_reg <= cfg_data;
            end
            if (commit_go) begin
                out_valid_reg <= 1'b1;
            end else if (out_ch.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        pred_reg    <= pred_next;
        res_reg     <= res_next;
        newpos_reg  <= newpos_next;
        newrate_reg <= newrate_next;
        if (uc.op == OP_RECIP_LO) begin
            scaled_mag_reg <= acc_abs[MUL_A_W-1:0];
            scaled_neg_reg <= acc_reg[ACC_W-1];
        end
        if (in_xfer) begin
            meas_reg <= $signed({in_ch.sample, 4'b0000});
            dt_reg   <= in_ch.interval_ms;
            init_reg <= in_ch.restart || !track_valid_reg || (in_ch.interval_ms == '0);
        end
        if (commit_go) begin
            out_ch.position        <= newpos_reg;
            out_ch.rate            <= newrate_reg;
            out_ch.initialized_now <= init_reg;
        end
    end

    a_no_accept_while_dividing: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_xfer |-> !div_busy
    ) else $error("Input transfer accepted while the divider is busy.");

    a_init_result_has_zero_rate: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.initialized_now) |-> (out_ch.rate == '0)
    ) else $error("Initializing result carries a nonzero rate.");

    a_commit_validates_track: assert property (
        @(posedge clk) disable iff (!rst_n)
        commit_go |=> (track_valid_reg && out_valid_reg && (pc_reg == STEP_IDLE))
    ) else $error("Commit did not leave a valid track and a pending result.");

endmodule

// File: rtl/abt_div.sv
// Bit-serial restoring divider with signed quotient, one quotient bit per cycle.
`timescale 1ns / 1ps

module abt_div import abt_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  div_req_t                req,
    output logic                    busy,
    output logic signed [ACC_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 neg_reg;
    logic [DT_W-1:0]      divisor_reg;
    logic [DT_W-1:0]      rem_reg;
    logic [DT_W-1:0]      rem_next;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     quo_next;
    logic [DT_W:0]        trial;
    logic [DT_W:0]        diff;
    logic                 fits;
    logic signed [ACC_W-1:0] magnitude;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = fits ? diff[DT_W-1:0] : trial[DT_W-1:0];
        quo_next  = {quo_reg[DIV_W-2:0], fits};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start) begin
            neg_reg     <= req.negative;
            divisor_reg <= req.divisor;
            rem_reg     <= '0;
            quo_reg     <= req.magnitude;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign magnitude = $signed(ACC_W'(quo_reg));
    assign quotient  = neg_reg ? -magnitude : magnitude;
    assign busy      = busy_reg;

endmodule

// File: bench/alpha_beta_tracker_core_tb.sv
// Self-checking testbench for the alpha-beta tracker core with a predicting scoreboard.
`timescale 1ns / 1ps

module alpha_beta_tracker_core_tb;
    import abt_pkg::*;

    typedef struct {
        int   position;
        int   rate;
        logic initialized_now;
    } estimate_t;

    class track_scoreboard;
        int        position_gain;
        int        velocity_gain;
        int        track_position;
        int        track_rate;
        bit        track_valid;
        estimate_t expected_estimates[$];
        int        mismatches;

        function new();
            position_gain  = int'(POSITION_GAIN_RESET);
            velocity_gain  = int'(VELOCITY_GAIN_RESET);
            track_position = 0;
            track_rate     = 0;
            track_valid    = 0;
            mismatches     = 0;
        endfunction

        function void set_gain(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            if (index == REG_POSITION_GAIN)
            begin
                position_gain = int'(value);
            end
            else if (index == REG_VELOCITY_GAIN)
            begin
                velocity_gain = int'(value);
            end
        endfunction

        function int clamp_track(longint x);
            if (x > 64'sd2147483647)
            begin
                return 32'sh7fffffff;
            end
            if (x < -64'sd2147483648)
            begin
                return 32'sh80000000;
            end
            return int'(x);
        endfunction

        function int pending();
            return expected_estimates.size();
        endfunction

        // Advances the track by one accepted sample and queues the estimate it gives.
        function void note_sample(logic signed [15:0] sample, logic [15:0] interval_ms,
                                  logic restart);
            longint    meas;
            longint    dt;
            longint    predicted;
            longint    residual;
            longint    pos_corr;
            longint    rate_quot;
            longint    rate_corr;
            estimate_t est;
            meas = longint'(sample) * 16;
            dt   = interval_ms;
            if (restart || !track_valid || dt == 0)
            begin
                track_position = clamp_track(meas);
                track_rate     = 0;
                track_valid    = 1;
                est.initialized_now = 1'b1;
            end
            else
            begin
                predicted = clamp_track(longint'(track_position)
                                        + (longint'(track_rate) * dt) / 1000);
                residual  = meas - predicted;
                pos_corr  = (longint'(position_gain) * residual) >>> GAIN_W;
                rate_quot = (longint'(velocity_gain) * residual * 1000) / dt;
                rate_corr = rate_quot >>> GAIN_W;
                track_position = clamp_track(predicted + pos_corr);
                track_rate     = clamp_track(longint'(track_rate) + rate_corr);
                est.initialized_now = 1'b0;
            end
            est.position = track_position;
            est.rate     = track_rate;
            expected_estimates.insert(expected_estimates.size(), est);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            mismatches++;
            $display("%0t ns: mismatch on %s: got %0d, expected %0d",
                     $realtime, what, got, want);
        endtask

        task check_estimate(int position, int rate, logic initialized_now);
            estimate_t est;
            if (expected_estimates.size() == 0)
            begin
                report_mismatch("unexpected result, position", position, 0);
                return;
            end
            est = expected_estimates[0];
            expected_estimates.delete(0);
            if (position != est.position)
            begin
                report_mismatch("position", position, est.position);
            end
            if (rate != est.rate)
            begin
                report_mismatch("rate", rate, est.rate);
            end
            if (initialized_now !== est.initialized_now)
            begin
                report_mismatch("initialized_now", initialized_now, est.initialized_now);
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    send_idle_pct;
    int                    recv_idle_pct;
    logic signed [15:0]    last_sample;
    track_scoreboard       sb = new();

    abt_in_if #(.SAMPLE_BITS(16)) in_ch();
    abt_out_if                    out_ch();

    alpha_beta_tracker_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                sb.check_estimate(out_ch.position, out_ch.rate, out_ch.initialized_now);
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
        else
        begin
            out_ch.ready <= 1'b0;
        end
    end

    task automatic send_sample(logic signed [15:0] sample, logic [15:0] interval_ms,
                               logic restart);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.sample      <= sample;
        in_ch.interval_ms <= interval_ms;
        in_ch.restart     <= restart;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        sb.note_sample(sample, interval_ms, restart);
        last_sample = sample;
    endtask

    task automatic drain(int settle);
        in_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_gains(logic [15:0] alpha, logic [15:0] beta);
        drain(8);
        cfg_we    <= 1'b1;
        cfg_index <= REG_POSITION_GAIN;
        cfg_data  <= alpha;
        @(posedge clk);
        sb.set_gain(REG_POSITION_GAIN, alpha);
        cfg_index <= REG_VELOCITY_GAIN;
        cfg_data  <= beta;
        @(posedge clk);
        sb.set_gain(REG_VELOCITY_GAIN, beta);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly a drifting measurement stream, with restarts, zero intervals and noise mixed in.
    task automatic run_track_phase(int count);
        int                 kind;
        int                 next;
        logic signed [15:0] smp;
        logic [15:0]        dt;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(79) == 0)
            begin
                drain(0);
            end
            kind = $urandom_range(99);
            if (kind < 8)
            begin
                send_sample(16'($urandom), 16'($urandom), 1'b1);
            end
            else if (kind < 16)
            begin
                send_sample(16'($urandom), 16'd0, 1'($urandom_range(1)));
            end
            else if (kind < 26)
            begin
                send_sample(16'($urandom), 16'($urandom), 1'($urandom_range(1)));
            end
            else
            begin
                if ($urandom_range(9) == 0)
                begin
                    next = int'(last_sample) + int'($urandom_range(8000)) - 4000;
                end
                else
                begin
                    next = int'(last_sample) + int'($urandom_range(400)) - 200;
                end
                smp = next[15:0];
                case ($urandom_range(3))
                    0: dt = 16'($urandom_range(20, 1));
                    1: dt = 16'($urandom_range(65535, 1));
                    default: dt = 16'($urandom_range(3000, 500));
                endcase
                send_sample(smp, dt, 1'b0);
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_POSITION_GAIN;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.sample      = '0;
        in_ch.interval_ms = '0;
        in_ch.restart     = 1'b0;
        last_sample       = '0;
        send_idle_pct     = 11;
        recv_idle_pct     = 50;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(16'sd100, 16'd1000, 1'b0);
        send_sample(16'sd120, 16'd1000, 1'b0);
        send_sample(16'sd140, 16'd1000, 1'b0);
        send_sample(16'sh7fff, 16'd1, 1'b0);
        send_sample(16'sh8000, 16'hffff, 1'b0);
        send_sample(16'sd0, 16'd0, 1'b0);
        send_sample(-16'sd1, 16'd500, 1'b0);
        send_sample(-16'sd1, 16'd500, 1'b1);
        send_sample(16'sh7fff, 16'd0, 1'b1);
        send_sample(16'sd1000, 16'hffff, 1'b0);
        send_sample(16'sh8000, 16'd1, 1'b0);

        write_gains(16'hffff, 16'hffff);
        send_sample(16'sh8000, 16'd100, 1'b1);
        send_sample(16'sh7fff, 16'd1, 1'b0);
        send_sample(16'sh7fff, 16'd1, 1'b0);
        send_sample(16'sh7fff, 16'hffff, 1'b0);
        send_sample(16'sh8000, 16'd1, 1'b0);
        send_sample(16'sh8000, 16'hffff, 1'b0);
        send_sample(16'sh8000, 16'hffff, 1'b0);

        run_track_phase(215);
        write_gains(16'd0, 16'd0);
        run_track_phase(215);

        send_idle_pct = 50;
        recv_idle_pct = 11;
        write_gains(16'd0, 16'hffff);
        run_track_phase(215);
        write_gains(16'hffff, 16'd0);
        run_track_phase(215);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_gains(16'($urandom), 16'($urandom));
        run_track_phase(215);
        write_gains(POSITION_GAIN_RESET, VELOCITY_GAIN_RESET);
        run_track_phase(215);

        drain(150);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
